// File: sv/dtp_pkg.sv
package dtp_pkg;

  // parse phases, one-hot
  typedef enum logic [5:0] {
    PH_LEAD   = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_DIGITS = 6'b000100,
    PH_TRAIL  = 6'b001000,
    PH_NUL    = 6'b010000,
    PH_FAIL   = 6'b100000
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] REG_CLAMP_EN = 2'd0;
  localparam logic [1:0] REG_CLAMP_MIN = 2'd1;
  localparam logic [1:0] REG_CLAMP_MAX = 2'd2;
  localparam logic [1:0] REG_FALLBACK = 2'd3;

  // register reset values
  localparam logic [31:0] CLAMP_MIN_RST = 32'h8000_0000;
  localparam logic [31:0] CLAMP_MAX_RST = 32'h7fff_ffff;
  localparam logic [31:0] FALLBACK_RST = 32'h0000_0000;

  // magnitude limits, wide enough for ten times the accumulator plus a digit
  localparam int unsigned PROD_W = 36;
  localparam logic [PROD_W-1:0] LIMIT_NEG = 36'h0_8000_0000;
  localparam logic [PROD_W-1:0] LIMIT_POS = 36'h0_7fff_ffff;

  // character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_PLUS = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // number whitespace: tab, lf, vt, ff, cr, space
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// File: sv/decimal_int32_text_parser_top.sv
// path: a beat with tlast passes the input, finished-string and result registers
// throughput: one input beat per cycle while the output is not stalled; the parse
//   state loop (multiply by ten, add digit, compare with the limit) is combinational
// reset: synchronous active-high rst clears the pipeline valids and the parse state
//   and loads the configuration registers with their defaults
module decimal_int32_text_parser_top
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic        m_axis_tuser,   // [0] parsed_ok
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic        clamp_enable;
  logic [31:0] clamp_min;
  logic [31:0] clamp_max;
  logic [31:0] fallback_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_enable   <= 1'b0;
      clamp_min      <= CLAMP_MIN_RST;
      clamp_max      <= CLAMP_MAX_RST;
      fallback_value <= FALLBACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLAMP_EN:  clamp_enable <= cfg_data[0];
        REG_CLAMP_MIN: clamp_min <= cfg_data;
        REG_CLAMP_MAX: clamp_max <= cfg_data;
        REG_FALLBACK:  fallback_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_has;
  logic       in_last;
  logic       fin_valid;
  logic       fin_ok;
  logic       fin_neg;
  logic [31:0] fin_mag;
  logic       out_valid;
  logic [31:0] out_value;
  logic       out_ok;

  logic out_free;
  logic fin_move;
  logic fin_free;
  logic in_go;

  assign out_free = !out_valid || m_axis_tready;
  assign fin_move = fin_valid && out_free;
  assign fin_free = !fin_valid || fin_move;
  assign in_go = in_valid && (!in_last || fin_free);
  assign s_axis_tready = !in_valid || in_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (in_go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_has  <= s_axis_tuser;
      in_last <= s_axis_tlast;
    end
  end

  // parse state
  phase_t      phase;
  phase_t      phase_next;
  logic        neg;
  logic        neg_next;
  logic [31:0] acc;
  logic [31:0] acc_next;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] limit;
  logic              over;
  logic              ok_next;

  // ten times the magnitude plus the digit, checked against the sign's limit
  assign prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, in_byte[3:0]};
  assign limit = neg ? LIMIT_NEG : LIMIT_POS;
  assign over = prod > limit;

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_next   = acc;
    if (in_has) begin
      case (phase)
        PH_LEAD: begin
          if (is_space(in_byte)) begin
            phase_next = PH_LEAD;
          end else if ((in_byte == CHAR_PLUS) || (in_byte == CHAR_MINUS)) begin
            neg_next   = (in_byte == CHAR_MINUS);
            phase_next = PH_SIGNED;
          end else if (is_digit(in_byte)) begin
            if (over) begin
              phase_next = PH_FAIL;
            end else begin
              acc_next   = prod[31:0];
              phase_next = PH_DIGITS;
            end
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_SIGNED, PH_DIGITS: begin
          if (is_digit(in_byte)) begin
            if (over) begin
              phase_next = PH_FAIL;
            end else begin
              acc_next   = prod[31:0];
              phase_next = PH_DIGITS;
            end
          end else if ((phase == PH_DIGITS) && is_space(in_byte)) begin
            phase_next = PH_TRAIL;
          end else if ((phase == PH_DIGITS) && (in_byte == CHAR_NUL)) begin
            phase_next = PH_NUL;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_TRAIL: begin
          if (is_space(in_byte)) begin
            phase_next = PH_TRAIL;
          end else if (in_byte == CHAR_NUL) begin
            phase_next = PH_NUL;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_NUL: begin
          if (in_byte != CHAR_NUL) begin
            phase_next = PH_FAIL;
          end
        end
        default: begin
          phase_next = PH_FAIL;
        end
      endcase
    end
  end

  assign ok_next = (phase_next == PH_DIGITS) || (phase_next == PH_TRAIL) ||
                   (phase_next == PH_NUL);

  // state update; the last beat of a string rearms the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      neg   <= 1'b0;
      acc   <= 32'b0;
    end else if (in_go) begin
      if (in_last) begin
        phase <= PH_LEAD;
        neg   <= 1'b0;
        acc   <= 32'b0;
      end else begin
        phase <= phase_next;
        neg   <= neg_next;
        acc   <= acc_next;
      end
    end
  end

  // finished-string register
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_go && in_last) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_last) begin
      fin_ok  <= ok_next;
      fin_neg <= neg_next;
      fin_mag <= acc_next;
    end
  end

  // apply sign, then clamp or fallback
  logic [31:0] signed_val;
  logic [31:0] value_next;

  assign signed_val = fin_neg ? (32'd0 - fin_mag) : fin_mag;

  always_comb begin
    value_next = signed_val;
    if (!fin_ok) begin
      value_next = fallback_value;
    end else if (clamp_enable) begin
      if ($signed(signed_val) < $signed(clamp_min)) begin
        value_next = clamp_min;
      end else if ($signed(clamp_max) < $signed(signed_val)) begin
        value_next = clamp_max;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      out_value <= value_next;
      out_ok    <= fin_ok;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_ok;

  // a positive magnitude stays below 2^31, a negative one at most 2^31
  assert property (@(posedge clk) disable iff (rst)
    acc[31] |-> (neg && (acc[30:0] == 31'b0)))
    else $error("magnitude accumulator beyond its limit");

  // the last beat of a string rearms the parser
  assert property (@(posedge clk) disable iff (rst)
    (in_go && in_last) |=> ((phase == PH_LEAD) && !neg && (acc == 32'b0)))
    else $error("parser not rearmed after a string");

  // a failed string stays failed until its last beat
  assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_FAIL) && !(in_go && in_last)) |=> (phase == PH_FAIL))
    else $error("parser left the fail phase inside a string");

  // a failed parse reports the fallback value
  assert property (@(posedge clk) disable iff (rst)
    (fin_move && !fin_ok) |=> (out_valid && !out_ok && (out_value == fallback_value)))
    else $error("failed parse did not give the fallback value");

  // with clamping off a good parse gives the signed magnitude unchanged
  assert property (@(posedge clk) disable iff (rst)
    (fin_move && fin_ok && !clamp_enable) |=>
      (out_ok && (out_value == ($past(fin_neg) ? (32'd0 - $past(fin_mag)) : $past(fin_mag)))))
    else $error("unclamped result differs from parsed magnitude");

endmodule

// File: tb/int32_parse_checker.sv
module int32_parse_checker
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] value
  input  logic        m_axis_tuser,   // [0] parsed_ok
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          results_owed,
  output int          results_seen,
  output int          parses_ok
);

  typedef struct packed {
    logic [31:0] value;
    logic        ok;
  } parse_result_t;

  // results owed by the block, oldest first
  parse_result_t pending_numbers[$];

  // shadow of the parse state
  phase_t      scan_phase;
  logic        neg_sign;
  logic [31:0] magnitude;

  // shadow of the registers
  logic        clamp_on;
  logic [31:0] lo_bound;
  logic [31:0] hi_bound;
  logic [31:0] fail_value;

  int miss_count;
  int seen_count;
  int ok_count;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

  function automatic void clear_scan();
    scan_phase = PH_LEAD;
    neg_sign = 1'b0;
    magnitude = '0;
  endfunction

  // exact overflow check: the grown magnitude may not pass the signed limit
  function automatic void fold_digit(input logic [7:0] c);
    longint unsigned grown;
    longint unsigned cap;
    cap = neg_sign ? 64'(LIMIT_NEG) : 64'(LIMIT_POS);
    grown = 64'(magnitude) * 64'd10 + 64'(c - CHAR_ZERO);
    if (grown > cap) begin
      scan_phase = PH_FAIL;
    end else begin
      magnitude = grown[31:0];
      scan_phase = PH_DIGITS;
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    case (scan_phase)
      PH_LEAD: begin
        if (is_blank(c)) begin
          scan_phase = PH_LEAD;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          neg_sign = (c == CHAR_MINUS);
          scan_phase = PH_SIGNED;
        end else if (is_numeral(c)) begin
          fold_digit(c);
        end else begin
          scan_phase = PH_FAIL;
        end
      end
      PH_SIGNED: begin
        if (is_numeral(c)) fold_digit(c);
        else scan_phase = PH_FAIL;
      end
      PH_DIGITS: begin
        if (is_numeral(c)) fold_digit(c);
        else if (is_blank(c)) scan_phase = PH_TRAIL;
        else if (c == CHAR_NUL) scan_phase = PH_NUL;
        else scan_phase = PH_FAIL;
      end
      PH_TRAIL: begin
        if (c == CHAR_NUL) scan_phase = PH_NUL;
        else if (!is_blank(c)) scan_phase = PH_FAIL;
      end
      PH_NUL: begin
        if (c != CHAR_NUL) scan_phase = PH_FAIL;
      end
      default: begin
        scan_phase = PH_FAIL;
      end
    endcase
  endfunction

  // outcome of the string so far, then rearm for the next one
  function automatic parse_result_t close_string();
    parse_result_t r;
    r.ok = scan_phase inside {PH_DIGITS, PH_TRAIL, PH_NUL};
    if (r.ok) begin
      r.value = neg_sign ? 32'd0 - magnitude : magnitude;
      if (clamp_on) begin
        if ($signed(r.value) < $signed(lo_bound)) r.value = lo_bound;
        else if ($signed(hi_bound) < $signed(r.value)) r.value = hi_bound;
      end
    end else begin
      r.value = fail_value;
    end
    clear_scan();
    return r;
  endfunction

  // watch config, input and result channels at each edge
  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      clear_scan();
      clamp_on = 1'b0;
      lo_bound = CLAMP_MIN_RST;
      hi_bound = CLAMP_MAX_RST;
      fail_value = FALLBACK_RST;
      pending_numbers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLAMP_EN:  clamp_on = cfg_data[0];
          REG_CLAMP_MIN: lo_bound = cfg_data;
          REG_CLAMP_MAX: hi_bound = cfg_data;
          REG_FALLBACK:  fail_value = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) scan_char(s_axis_tdata);
        if (s_axis_tlast) pending_numbers.push_back(close_string());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_count++;
        if (pending_numbers.size() == 0) begin
          if (miss_count < 10)
            $display("result beat with no string pending: value %0d parsed_ok %0b",
                     $signed(m_axis_tdata), m_axis_tuser);
          miss_count++;
        end else begin
          want = pending_numbers.pop_front();
          if (want.ok) ok_count++;
          if (m_axis_tdata !== want.value || m_axis_tuser !== want.ok) begin
            if (miss_count < 10)
              $display("result mismatch: value exp %0d got %0d, parsed_ok exp %0b got %0b",
                       $signed(want.value), $signed(m_axis_tdata), want.ok, m_axis_tuser);
            miss_count++;
          end
        end
      end
    end
    mismatches <= miss_count;
    results_owed <= pending_numbers.size();
    results_seen <= seen_count;
    parses_ok <= ok_count;
  end

endmodule

// File: tb/tb_decimal_int32_text_parser_top.sv
module tb_decimal_int32_text_parser_top;
  import dtp_pkg::*;

  localparam int RAND_BEATS = 135;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 6;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_byte
  logic        s_axis_tuser;   // [0] has_char
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] value
  logic        m_axis_tuser;   // [0] parsed_ok
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int mismatches;
  int results_owed;
  int results_seen;
  int parses_ok;

  int tx_idle;
  int rx_idle;
  int hold_asks;
  int quiet_cycles;
  int beats_sent;
  int strings_sent;

  // bytes of the string being sent
  logic [7:0] text[$];

  // magnitudes around the signed 32-bit limits
  longint unsigned limit_mags[8] = '{64'd0, 64'd2147483646, 64'd2147483647, 64'd2147483648,
                                     64'd2147483649, 64'd4294967295, 64'd9999999999,
                                     64'd21474836480};

  decimal_int32_text_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  int32_parse_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .results_owed  (results_owed),
    .results_seen  (results_seen),
    .parses_ok     (parses_ok)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // result side: random stalls, or a long hold-off when asked
  initial begin
    int hold_seen;
    hold_seen = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d results still owed",
               QUIET_LIMIT, results_owed);
      $display("[decimal_int32_text_parser_top] ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] ch, input logic has, input logic fin);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tuser <= has;
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
    if (has || fin) beats_sent++;
    if (fin) strings_sent++;
  endtask

  // send the queued bytes, with stray empty beats and an optional empty closing beat
  task automatic send_text(input bit term);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 99) < 4) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(text[i], 1'b1, !term && i == text.size() - 1);
    end
    if (term || text.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(0, 5) == 5) return CHAR_SPACE;
    return CHAR_TAB + 8'($urandom_range(0, 4));
  endfunction

  // mostly well-formed numbers with random content, some noise and damage
  task automatic build_text();
    int shape;
    longint unsigned mag;
    longint unsigned tens;
    text.delete();
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      repeat ($urandom_range(1, 4)) text.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
    case ($urandom_range(0, 3))
      0: text.push_back(CHAR_PLUS);
      1: text.push_back(CHAR_MINUS);
      default: ;
    endcase
    if (shape >= 36) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) text.push_back(CHAR_ZERO);
      if (shape < 60) begin
        mag = limit_mags[$urandom_range(0, 7)];
      end else begin
        tens = 1;
        repeat ($urandom_range(1, 9)) tens *= 10;
        mag = longint'($urandom) % tens;
      end
      push_string($sformatf("%0d", mag));
    end
    repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) text.push_back(CHAR_NUL);
      if ($urandom_range(0, 19) == 0) text.push_back(pick_blank());
    end
    if (text.size() > 0 && $urandom_range(0, 99) < 12)
      text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int p);
    logic        en;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] fb;
    case (p)
      0: begin en = 1'b1; lo = -1000; hi = 1000; fb = 32'h7fff_ffff; end
      1: begin en = 1'b1; lo = 32'h7fff_ffff; hi = 32'h8000_0000; fb = 32'h8000_0000; end
      2: begin en = 1'b1; lo = 50; hi = -50; fb = 32'hffff_ffff; end
      3: begin en = 1'b0; lo = 0; hi = 0; fb = $urandom; end
      4: begin en = 1'b1; lo = 32'h8000_0000; hi = 32'h7fff_ffff; fb = 0; end
      default: begin
        en = 1'($urandom);
        lo = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2000)) - 1000;
        hi = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2000)) - 1000;
        fb = $urandom;
      end
    endcase
    write_reg(REG_CLAMP_EN, {31'd0, en});
    write_reg(REG_CLAMP_MIN, lo);
    write_reg(REG_CLAMP_MAX, hi);
    write_reg(REG_FALLBACK, fb);
    cfg_we <= 1'b0;
  endtask

  // stop offering, wait for every owed result, then let the pipe drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int target;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle = 0;
    rx_idle = 0;
    hold_asks = 0;
    beats_sent = 0;
    strings_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed strings under reset register values
    send_beat(8'($urandom), 1'b0, 1'b1);          // empty string
    text = '{CHAR_MINUS};                          // sign with no digits
    send_text(1'b0);
    text = '{CHAR_TAB, CHAR_NINE, CHAR_SPACE, CHAR_NUL};
    send_text(1'b0);
    text.delete();
    push_string("-2147483648");
    send_text(1'b0);
    send_beat(8'hff, 1'b1, 1'b1);                 // bad byte, all bits set
    send_beat(CHAR_NUL, 1'b1, 1'b1);              // nul before any digit
    text.delete();
    push_string("5");
    text.push_back(CHAR_NUL);
    text.push_back(CHAR_SPACE);                    // blank after nul
    send_text(1'b0);
    send_beat(CHAR_ZERO + 8'd3, 1'b1, 1'b0);
    send_beat(8'($urandom), 1'b0, 1'b0);          // beat with no byte and no end
    send_beat(8'($urandom), 1'b0, 1'b1);          // empty closing beat

    // random strings over six register settings and three pacing modes
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p / 2)
        0: begin tx_idle = 25; rx_idle = 58; end
        1: begin tx_idle = 58; rx_idle = 25; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      apply_setting(p);
      if (p == 1 || p == 4) hold_asks <= hold_asks + 1;
      target = beats_sent + RAND_BEATS;
      while (beats_sent < target) begin
        build_text();
        send_text($urandom_range(0, 99) < 12);
      end
    end
    settle();

    $display("covered %0d beats in %0d strings: directed cases, six register settings",
             beats_sent, strings_sent);
    $display("checked %0d results (%0d parsed, %0d rejected) under three pacing modes",
             results_seen, parses_ok, results_seen - parses_ok);
    if (mismatches == 0 && results_owed == 0) begin
      $display("[decimal_int32_text_parser_top] OK");
    end else begin
      $display("[decimal_int32_text_parser_top] ERROR");
    end
    $finish;
  end

endmodule
